/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fbfl_pkg.sv */
package fbfl_pkg;

  localparam int POOL_BLOCKS_DEF = 256;

  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic accept_free;
    logic accept_alloc;
    logic alloc_finish;
    logic load_out;
  } fbfl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic alloc_ok;
  } fbfl_sts_t;

endpackage

/* src/fbfl_if.sv */
interface fbfl_req_if import fbfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [INDEX_W-1:0] free_index;

  modport source (output valid, output req_type, output free_index, input ready);
  modport sink (input valid, input req_type, input free_index, output ready);
endinterface

interface fbfl_rsp_if import fbfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  block_index;
  logic [COUNT_W-1:0]  used_count;

  modport source (output valid, output status, output block_index, output used_count,
                  input ready);
  modport sink (input valid, input status, input block_index, input used_count,
                output ready);
endinterface

/* src/fbfl_ram.sv */
module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/fbfl_ctrl.sv */
module fbfl_ctrl import fbfl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_req_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fbfl_sts_t  sts,
  output fbfl_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       accept;

  always_comb begin
    in_ready = (state == S_IDLE) && (!out_valid || out_ready);
    accept   = in_valid && in_ready;

    cmd.clear_step   = (state == S_CLEAR);
    cmd.accept_free  = accept && (in_req_type == REQ_FREE);
    cmd.accept_alloc = accept && (in_req_type == REQ_ALLOC);
    cmd.alloc_finish = (state == S_ALLOC);
    cmd.load_out     = cmd.accept_free || (cmd.accept_alloc && !sts.alloc_ok) ||
                       cmd.alloc_finish;

    out_valid_next = cmd.load_out ? 1'b1 : (out_valid && !out_ready);

    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.accept_alloc && sts.alloc_ok) begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/fbfl_datapath.sv */
module fbfl_datapath import fbfl_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fbfl_cmd_t           cmd,
  output fbfl_sts_t           sts,
  input  logic [INDEX_W-1:0]  free_index,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  block_index,
  output logic [COUNT_W-1:0]  used_count
);

  localparam int AW = $clog2(POOL_BLOCKS);
  localparam int IW = $clog2(POOL_BLOCKS + 1);
  localparam int XW = (IW > INDEX_W) ? IW : INDEX_W + 1;

  logic [AW-1:0]       clr_addr;
  logic [IW-1:0]       head;
  logic [IW-1:0]       head_next;
  logic [IW-1:0]       count;
  logic [IW-1:0]       count_next;
  logic [XW-1:0]       idx_ext;
  logic [XW-1:0]       head_ext;
  logic [XW-1:0]       count_ext;
  logic                idx_ok;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [IW-1:0]       wr_data;
  logic [IW-1:0]       rd_data;
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_block;

  // next-index table
  fbfl_ram #(
    .WIDTH (IW),
    .DEPTH (POOL_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (head[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    idx_ext  = XW'(free_index);
    head_ext = XW'(head);
    idx_ok   = idx_ext < XW'(POOL_BLOCKS);

    sts.alloc_ok   = (count < IW'(POOL_BLOCKS)) && (head < IW'(POOL_BLOCKS));
    sts.clear_last = (clr_addr == AW'(POOL_BLOCKS - 1));

    // clearing pass writes entry n with n plus one
    wr_en   = cmd.clear_step;
    wr_addr = clr_addr;
    wr_data = IW'(clr_addr) + IW'(1);
    if (cmd.accept_free && idx_ok) begin
      wr_en   = 1'b1;
      wr_addr = idx_ext[AW-1:0];
      wr_data = head;
    end

    head_next  = head;
    count_next = count;
    if (cmd.accept_free && idx_ok) begin
      head_next  = idx_ext[IW-1:0];
      count_next = (count == '0) ? count : count - IW'(1);
    end else if (cmd.alloc_finish) begin
      head_next  = rd_data;
      count_next = count + IW'(1);
    end
    count_ext = XW'(count_next);

    if (cmd.accept_free) begin
      res_status = idx_ok ? STATUS_OK : STATUS_RANGE;
    end else if (cmd.accept_alloc) begin
      res_status = STATUS_EXHAUSTED;
    end else begin
      res_status = STATUS_OK;
    end
    res_block = cmd.alloc_finish ? head_ext[INDEX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      head     <= '0;
      count    <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= res_status;
      block_index <= res_block;
      used_count  <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

/* src/fixed_block_free_list_core.sv */
// results: a free or a refused allocate shows its result in the cycle after acceptance;
// a granted allocate's result waits on the registered read of the next-index table first
// throughput: 1 item per cycle for frees while results are taken; a granted allocate
// holds off the next item; the output register lets a new item in during the cycle
// its result is taken. reset: synchronous; a clearing pass rebuilds the table entry by
// entry, during which no item is accepted
module fixed_block_free_list_core import fbfl_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input logic       clk,
  input logic       rst,
  fbfl_req_if.sink  req,
  fbfl_rsp_if.source rsp
);

  fbfl_cmd_t cmd;
  fbfl_sts_t sts;

  fbfl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  fbfl_datapath #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .free_index  (req.free_index),
    .status      (rsp.status),
    .block_index (rsp.block_index),
    .used_count  (rsp.used_count)
  );

endmodule

/* src/fbfl_checker.sv */
`include "assert_macros.svh"

module fbfl_checker import fbfl_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [INDEX_W-1:0]  block_index,
  input logic [COUNT_W-1:0]  used_count
);

  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(block_index) && $stable(used_count), "result changed while stalled")
  `ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, out_valid || !in_ready, "item accepted with no result pending or in work")
  `ASSERT_IMP(a_refused_zero, out_valid && status != STATUS_OK, block_index == '0, "refused request gave a block index")
  `ASSERT_IMP(a_count_bound, out_valid, POOL_BLOCKS > 511 || 32'(used_count) <= POOL_BLOCKS, "used count beyond pool size")

endmodule

bind fixed_block_free_list_core fbfl_checker #(
  .POOL_BLOCKS (POOL_BLOCKS)
) u_fbfl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .status      (rsp.status),
  .block_index (rsp.block_index),
  .used_count  (rsp.used_count)
);

/* tb/sv/fixed_block_free_list_core_tb.sv */
`timescale 1ns / 100ps

module fixed_block_free_list_core_tb import fbfl_pkg::*; ();

  localparam int POOL          = POOL_BLOCKS_DEF;
  localparam int TAIL_ITEMS    = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic               req_type;
    logic [INDEX_W-1:0] free_index;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  block_index;
    logic [COUNT_W-1:0]  used_count;
  } rsp_item_t;

  typedef struct packed {
    logic [POOL-1:0][COUNT_W-1:0] link;
    logic [COUNT_W-1:0]           head;
    logic [COUNT_W-1:0]           used;
  } pool_state_t;

  logic clk = 1'b0;
  logic rst;

  fbfl_req_if req ();
  fbfl_rsp_if rsp ();

  fixed_block_free_list_core #(.POOL_BLOCKS(POOL)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_item_t          pending[$];
  rsp_item_t          owed_results[$];
  logic [INDEX_W-1:0] held[$];
  pool_state_t        plan;
  pool_state_t        live;
  req_item_t          on_wire;
  rsp_item_t          seen;
  rsp_item_t          want;
  int                 total_items = 0;
  int                 sent_count = 0;
  int                 fault_count = 0;
  int                 send_gap;
  int                 sink_gap;

  function automatic pool_state_t fresh_pool();
    pool_state_t st;
    st = '0;
    for (int n = 0; n < POOL; n++) begin
      st.link[n] = COUNT_W'(n + 1);
    end
    return st;
  endfunction

  function automatic rsp_item_t free_list_step(inout pool_state_t st, input req_item_t rq);
    rsp_item_t r;
    r = '0;
    r.status = STATUS_OK;
    if (rq.req_type == REQ_ALLOC) begin
      if (st.used >= POOL || st.head >= POOL) begin
        r.status = STATUS_EXHAUSTED;
      end else begin
        r.block_index = st.head[INDEX_W-1:0];
        st.head = st.link[st.head];
        st.used = st.used + 1'b1;
      end
    end else if (rq.free_index >= POOL) begin
      r.status = STATUS_RANGE;
    end else begin
      st.link[rq.free_index] = st.head;
      st.head = {1'b0, rq.free_index};
      if (st.used != 0) begin
        st.used = st.used - 1'b1;
      end
    end
    r.used_count = st.used;
    return r;
  endfunction

  task automatic queue_request(input logic kind, input logic [INDEX_W-1:0] idx);
    req_item_t rq;
    rsp_item_t r;
    rq.req_type = kind;
    rq.free_index = idx;
    r = free_list_step(plan, rq);
    if (kind == REQ_ALLOC && r.status == STATUS_OK) begin
      held.push_back(r.block_index);
    end else if (kind == REQ_FREE) begin
      for (int k = 0; k < held.size(); k++) begin
        if (held[k] == idx) begin
          held.delete(k);
          break;
        end
      end
    end
    pending.push_back(rq);
  endtask

  task automatic queue_free_held();
    queue_request(REQ_FREE, held[$urandom_range(0, held.size() - 1)]);
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = REQ_ALLOC;
    req.free_index = '0;
    rsp.ready = 1'b0;
    plan = fresh_pool();
    live = fresh_pool();

    queue_request(REQ_ALLOC, 8'hFF);
    queue_request(REQ_ALLOC, 8'h00);
    queue_request(REQ_ALLOC, 8'hAA);
    queue_request(REQ_ALLOC, 8'h55);
    queue_request(REQ_FREE, 8'd1);
    queue_request(REQ_FREE, 8'd3);
    queue_request(REQ_ALLOC, 8'h0F);
    queue_request(REQ_ALLOC, 8'hF0);
    queue_request(REQ_FREE, 8'd0);
    queue_request(REQ_FREE, 8'd2);
    queue_request(REQ_FREE, 8'd1);
    queue_request(REQ_FREE, 8'd3);

    repeat (10) begin
      if (held.size() != 0 && $urandom_range(0, 1) == 1) queue_free_held();
      else queue_request(REQ_ALLOC, INDEX_W'($urandom()));
    end
    // fill the pool, then run into exhaustion
    while (held.size() < POOL) begin
      if (held.size() != 0 && $urandom_range(0, 39) == 0) queue_free_held();
      else queue_request(REQ_ALLOC, INDEX_W'($urandom()));
    end
    repeat (4) queue_request(REQ_ALLOC, INDEX_W'($urandom()));
    while (held.size() != 0) begin
      if ($urandom_range(0, 39) == 0) queue_request(REQ_ALLOC, INDEX_W'($urandom()));
      else queue_free_held();
    end
    // free with nothing in use, then unchecked traffic
    queue_request(REQ_FREE, INDEX_W'($urandom()));
    repeat (12) queue_request(1'($urandom_range(0, 1)), INDEX_W'($urandom()));
    total_items = pending.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req.valid && req.ready) begin
        owed_results.push_back(free_list_step(live, on_wire));
        sent_count <= sent_count + 1;
      end
      if (!req.valid || req.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req.valid <= 1'b0;
        end else if (sent_count + TAIL_ITEMS < total_items && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 9);
          req.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          on_wire = pending.pop_front();
          req.valid <= 1'b1;
          req.req_type <= on_wire.req_type;
          req.free_index <= on_wire.free_index;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen.status = rsp.status;
        seen.block_index = rsp.block_index;
        seen.used_count = rsp.used_count;
        if (owed_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: unexpected item status %0d block_index %0d used_count %0d",
                     $time, seen.status, seen.block_index, seen.used_count);
          end
        end else begin
          want = owed_results.pop_front();
          if (seen != want) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("%0t: mismatch status %0d/%0d block_index %0d/%0d used_count %0d/%0d",
                       $time, want.status, seen.status, want.block_index, seen.block_index,
                       want.used_count, seen.used_count);
            end
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        rsp.ready <= 1'b0;
      end else if (sent_count + TAIL_ITEMS < total_items && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 9);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    int settle;
    idle = 0;
    settle = 0;
    while (idle < STALL_LIMIT && settle < SETTLE_CYCLES) begin
      @(negedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
      if (!rst && pending.size() == 0 && !req.valid && owed_results.size() == 0) settle++;
      else settle = 0;
    end
    if (idle >= STALL_LIMIT) begin
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/fbfl_pkg.sv
src/fbfl_if.sv
src/fbfl_ram.sv
src/fbfl_ctrl.sv
src/fbfl_datapath.sv
src/fixed_block_free_list_core.sv
src/fbfl_checker.sv
tb/sv/fixed_block_free_list_core_tb.sv
